[rtl/ecq_pkg.sv]
// shared widths, constants and tables for the euler to quaternion pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package ecq_pkg;

    localparam int ANG_W       = 16;  // Q3.12 angle input
    localparam int Q_W         = 16;  // Q1.14 quaternion output
    localparam int Z_W         = 34;  // Q.30 residual angle
    localparam int XY_W        = 33;  // Q.30 cordic vector
    localparam int CS_W        = 18;  // Q.16 cosine and sine
    localparam int MIN_STAGES  = 8;
    localparam int MAX_STAGES  = 24;
    localparam int DEF_STAGES  = 14;

    localparam logic signed [Z_W-1:0] PI_Q30      = Z_W'(64'sd3373259426);
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'sd1686629713);
    localparam logic signed [Q_W-1:0] ONE_Q14     = Q_W'(16384);

    function automatic int clamp_stages(input int n);
        int r;
        r = n;
        if (r < MIN_STAGES) begin
            r = MIN_STAGES;
        end
        if (r > MAX_STAGES) begin
            r = MAX_STAGES;
        end
        return r;
    endfunction

    // atan(2^-i) in Q.30
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = Z_W'(843314857);
            1:       r = Z_W'(497837829);
            2:       r = Z_W'(263043837);
            3:       r = Z_W'(133525159);
            4:       r = Z_W'(67021687);
            5:       r = Z_W'(33543516);
            6:       r = Z_W'(16775851);
            7:       r = Z_W'(8388437);
            8:       r = Z_W'(4194283);
            9:       r = Z_W'(2097149);
            10:      r = Z_W'(1048576);
            11:      r = Z_W'(524288);
            12:      r = Z_W'(262144);
            13:      r = Z_W'(131072);
            14:      r = Z_W'(65536);
            15:      r = Z_W'(32768);
            16:      r = Z_W'(16384);
            17:      r = Z_W'(8192);
            18:      r = Z_W'(4096);
            19:      r = Z_W'(2048);
            20:      r = Z_W'(1024);
            21:      r = Z_W'(512);
            22:      r = Z_W'(256);
            23:      r = Z_W'(128);
            default: r = '0;
        endcase
        return r;
    endfunction

    // cordic gain compensation in Q.30 for a given stage count
    function automatic logic signed [XY_W-1:0] gain_q30(input int n);
        logic signed [XY_W-1:0] r;
        case (n)
            8:       r = XY_W'(652039507);
            9:       r = XY_W'(652034532);
            10:      r = XY_W'(652033289);
            11:      r = XY_W'(652032978);
            12:      r = XY_W'(652032900);
            13:      r = XY_W'(652032880);
            14:      r = XY_W'(652032876);
            default: r = XY_W'(652032874);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/euler_to_quaternion.sv]
// top level: euler angles to unit quaternion, fully pipelined
// depends on ecq_pkg, ecq_cordic (one per axis) and ecq_combine
//
// usage:
//   a transaction enters when i_start is high and o_busy is low; o_busy is
//   tied low, so a new angle triple can enter on every clock cycle.
//   each transaction produces exactly one quaternion, presented on o_quat_*
//   for one cycle with o_valid high; results come out in input order.
// pipeline: one reduction stage, one cordic stage per iteration and one
//   rounding stage in each ecq_cordic, then four product and rounding
//   stages in ecq_combine; CORDIC_STAGES is clamped to 8..24.
// throughput: one transaction per cycle, set by the unrolled cordic and the
//   registered multiplier stages.
// reset: synchronous, active low; clears the valid bits so no result is
//   strobed for data that was in flight. the data registers are not reset.
// the receiver cannot stall: every result must be taken in its strobe cycle.
`default_nettype none

module euler_to_quaternion #(
    parameter int CORDIC_STAGES = ecq_pkg::DEF_STAGES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [ecq_pkg::ANG_W-1:0]  i_angle_x,
    input  wire logic signed [ecq_pkg::ANG_W-1:0]  i_angle_y,
    input  wire logic signed [ecq_pkg::ANG_W-1:0]  i_angle_z,
    output logic                                   o_valid,
    output logic signed [ecq_pkg::Q_W-1:0]         o_quat_w,
    output logic signed [ecq_pkg::Q_W-1:0]         o_quat_x,
    output logic signed [ecq_pkg::Q_W-1:0]         o_quat_y,
    output logic signed [ecq_pkg::Q_W-1:0]         o_quat_z
);
    import ecq_pkg::*;

    localparam int STAGES  = clamp_stages(CORDIC_STAGES);
    localparam int CLAT    = STAGES + 2;

    logic signed [CS_W-1:0] cx, sx, cy, sy, cz, sz;
    logic [CLAT-1:0]        r_vld;

    assign o_busy = 1'b0;

    // valid bits matching the cordic latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CLAT-2:0], i_start & ~o_busy};
        end
    end

    ecq_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk   (i_clk),
        .i_angle (i_angle_x),
        .o_cos   (cx),
        .o_sin   (sx)
    );

    ecq_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk   (i_clk),
        .i_angle (i_angle_y),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    ecq_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk   (i_clk),
        .i_angle (i_angle_z),
        .o_cos   (cz),
        .o_sin   (sz)
    );

    ecq_combine u_combine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[CLAT-1]),
        .i_cx     (cx),
        .i_sx     (sx),
        .i_cy     (cy),
        .i_sy     (sy),
        .i_cz     (cz),
        .i_sz     (sz),
        .o_valid  (o_valid),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

endmodule

`default_nettype wire

[rtl/ecq_cordic.sv]
// half-angle cosine and sine: range reduction, unrolled cordic, rounding
// depends on ecq_pkg; the reduction, each iteration and the rounding are registered
`default_nettype none

module ecq_cordic #(
    parameter int CORDIC_STAGES = ecq_pkg::DEF_STAGES
) (
    input  wire logic                               i_clk,
    input  wire logic signed [ecq_pkg::ANG_W-1:0]   i_angle,
    output logic signed [ecq_pkg::CS_W-1:0]         o_cos,
    output logic signed [ecq_pkg::CS_W-1:0]         o_sin
);
    import ecq_pkg::*;

    localparam int STAGES = clamp_stages(CORDIC_STAGES);
    localparam logic signed [XY_W:0] RND = (XY_W+1)'(8192);

    logic signed [XY_W-1:0] r_x [0:STAGES];
    logic signed [XY_W-1:0] r_y [0:STAGES];
    logic signed [Z_W-1:0]  r_z [0:STAGES];
    logic                   r_f [0:STAGES];

    logic signed [Z_W-1:0] z_in;
    logic signed [Z_W-1:0] n_z0;
    logic                  n_f0;

    // raw Q3.12 read as the Q.13 half angle, then widened to Q.30
    assign z_in = {{(Z_W-ANG_W-17){i_angle[ANG_W-1]}}, i_angle, 17'b0};

    always_comb begin
        n_z0 = z_in;
        n_f0 = 1'b0;
        if (z_in > HALF_PI_Q30) begin
            n_z0 = z_in - PI_Q30;
            n_f0 = 1'b1;
        end else if (z_in < -HALF_PI_Q30) begin
            n_z0 = z_in + PI_Q30;
            n_f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= gain_q30(STAGES);
        r_y[0] <= '0;
        r_z[0] <= n_z0;
        r_f[0] <= n_f0;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!r_z[i][Z_W-1]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - atan_q30(i);
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + atan_q30(i);
            end
            r_f[i+1] <= r_f[i];
        end
    end

    logic signed [XY_W:0] xf;
    logic signed [XY_W:0] yf;
    logic signed [XY_W:0] xr;
    logic signed [XY_W:0] yr;

    // undo the half-turn reduction, then round Q.30 to Q.16
    always_comb begin
        xf = (XY_W+1)'(r_x[STAGES]);
        yf = (XY_W+1)'(r_y[STAGES]);
        if (r_f[STAGES]) begin
            xf = -xf;
            yf = -yf;
        end
        xr = (xf + RND) >>> 14;
        yr = (yf + RND) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        o_cos <= xr[CS_W-1:0];
        o_sin <= yr[CS_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/ecq_combine.sv]
// quaternion assembly: pair products, triple products, sums, round and saturate
// depends on ecq_pkg; four register stages with a travelling valid bit
`default_nettype none

module ecq_combine (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic signed [ecq_pkg::CS_W-1:0]  i_cx,
    input  wire logic signed [ecq_pkg::CS_W-1:0]  i_sx,
    input  wire logic signed [ecq_pkg::CS_W-1:0]  i_cy,
    input  wire logic signed [ecq_pkg::CS_W-1:0]  i_sy,
    input  wire logic signed [ecq_pkg::CS_W-1:0]  i_cz,
    input  wire logic signed [ecq_pkg::CS_W-1:0]  i_sz,
    output logic                                  o_valid,
    output logic signed [ecq_pkg::Q_W-1:0]        o_quat_w,
    output logic signed [ecq_pkg::Q_W-1:0]        o_quat_x,
    output logic signed [ecq_pkg::Q_W-1:0]        o_quat_y,
    output logic signed [ecq_pkg::Q_W-1:0]        o_quat_z
);
    import ecq_pkg::*;

    localparam int PP_W  = 2 * CS_W;
    localparam int TP_W  = PP_W + CS_W;
    localparam int SUM_W = TP_W + 1;
    localparam int RD_W  = SUM_W - 34;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'sd1 <<< 33);

    function automatic logic signed [Q_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [RD_W-1:0]  r;
        logic signed [Q_W-1:0]   q;
        t = v + RND;
        r = $signed(t[SUM_W-1:34]);
        if (r > RD_W'(ONE_Q14)) begin
            q = ONE_Q14;
        end else if (r < -RD_W'(ONE_Q14)) begin
            q = -ONE_Q14;
        end else begin
            q = r[Q_W-1:0];
        end
        return q;
    endfunction

    logic [3:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // stage 1: pair products
    logic signed [PP_W-1:0] r_czcy, r_szsy, r_sycz, r_cysz;
    logic signed [CS_W-1:0] r_cx, r_sx;

    always_ff @(posedge i_clk) begin
        r_czcy <= i_cy * i_cz;
        r_szsy <= i_sy * i_sz;
        r_sycz <= i_sy * i_cz;
        r_cysz <= i_cy * i_sz;
        r_cx   <= i_cx;
        r_sx   <= i_sx;
    end

    // stage 2: triple products, exact in Q.48
    logic signed [TP_W-1:0] r_wa, r_wb, r_xa, r_xb, r_ya, r_yb, r_za, r_zb;

    always_ff @(posedge i_clk) begin
        r_wa <= r_czcy * r_cx;
        r_wb <= r_szsy * r_sx;
        r_xa <= r_czcy * r_sx;
        r_xb <= r_szsy * r_cx;
        r_ya <= r_sycz * r_cx;
        r_yb <= r_cysz * r_sx;
        r_za <= r_cysz * r_cx;
        r_zb <= r_sycz * r_sx;
    end

    // stage 3: component sums
    logic signed [SUM_W-1:0] r_sw, r_sx3, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        r_sw  <= SUM_W'(r_wa) - SUM_W'(r_wb);
        r_sx3 <= SUM_W'(r_xa) + SUM_W'(r_xb);
        r_sy  <= SUM_W'(r_ya) + SUM_W'(r_yb);
        r_sz  <= SUM_W'(r_za) - SUM_W'(r_zb);
    end

    // stage 4: round to Q1.14 and clip at plus or minus one
    always_ff @(posedge i_clk) begin
        o_quat_w <= round_sat(r_sw);
        o_quat_x <= round_sat(r_sx3);
        o_quat_y <= round_sat(r_sy);
        o_quat_z <= round_sat(r_sz);
    end

    assign o_valid = r_vld[3];

endmodule

`default_nettype wire
